// ===== design/pps_pkg.sv =====
// Shared types, field widths and helpers for the preemptive priority scheduler.
package pps_pkg;

  // Field widths of one input item and one result item
  localparam int FUNC_W  = 1;
  localparam int SLOT_W5 = 5;
  localparam int PRIO_W  = 8;
  localparam int BURST_W = 16;
  localparam int OUT16_W = 16;

  // Stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 56;

  // Item kinds carried on in_tuser
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_FETCH,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic scan_clr;
    logic scan_step;
    logic fetch;
    logic add_do;
    logic tick_do;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_func;
    logic scan_done;
  } status_t;

  // Clamp a time value to the 16-bit result fields
  function automatic logic [OUT16_W-1:0] sat16(input logic [31:0] v);
    logic [OUT16_W-1:0] r;
    r = (v > 32'h0000_FFFF) ? 16'hFFFF : v[OUT16_W-1:0];
    return r;
  endfunction

endpackage

// ===== design/pps_ctrl.sv =====
// Controller state machine: sequences add, slot scan, fetch and result transfer.
module pps_ctrl
  import pps_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register can take a new result
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (status.in_func == FUNC_TICK) ? ST_SCAN : ST_ADD;
        end
      end
      ST_ADD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.scan_done) state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_in  = in_tvalid;
        cmd.scan_clr = in_tvalid;
      end
      ST_ADD:    cmd.add_do    = out_free;
      ST_SCAN:   cmd.scan_step = !status.scan_done;
      ST_FETCH:  cmd.fetch     = 1'b1;
      ST_FINISH: cmd.tick_do   = out_free;
      default:   cmd = '0;
    endcase
  end

  // Result valid: set on load, cleared once the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.add_do || cmd.tick_do) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/pps_datapath.sv =====
// Datapath: job memories, ready mask, priority scan, time counter and result register.
module pps_datapath
  import pps_pkg::*;
#(
  parameter int SLOTS     = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = SLOT_W + 1;

  // Job memories, one entry per slot
  logic [PRIO_W-1:0]    prio_mem  [SLOTS];
  logic [BURST_W-1:0]   burst_mem [SLOTS];
  logic [BURST_W-1:0]   left_mem  [SLOTS];
  logic [TIME_BITS-1:0] arr_mem   [SLOTS];

  logic [SLOTS-1:0]     ready_r;
  logic [TIME_BITS-1:0] time_r;

  // Latched input item
  logic [SLOT_W5-1:0]   slot_r;
  logic [PRIO_W-1:0]    prio_r;
  logic [BURST_W-1:0]   burst_r;

  // Scan state
  logic [IDX_W-1:0]     idx_r;
  logic                 pend_r;
  logic [SLOT_W-1:0]    pend_idx_r;
  logic [PRIO_W-1:0]    prio_rd_r;
  logic                 found_r;
  logic [SLOT_W-1:0]    best_idx_r;
  logic [PRIO_W-1:0]    best_prio_r;

  // Fetched job of the winner
  logic [BURST_W-1:0]   left_rd_r;
  logic [BURST_W-1:0]   burst_rd_r;
  logic [TIME_BITS-1:0] arr_rd_r;

  logic [OUT_DATA_W-1:0] out_data_r;

  logic                 slot_ok;
  logic [SLOT_W-1:0]    slot_idx;
  logic                 add_err;
  logic                 add_wr;
  logic                 issue;
  logic                 better;
  logic [BURST_W-1:0]   left_new;
  logic                 fin;
  logic [TIME_BITS-1:0] t_el;
  logic [31:0]          t32;
  logic [31:0]          burst32;
  logic [OUT16_W-1:0]   tat;
  logic [OUT16_W-1:0]   wt;
  logic [OUT16_W-1:0]   now16;

  assign status.in_func   = in_tuser[0];
  assign status.scan_done = (idx_r == IDX_W'(SLOTS)) && !pend_r;

  // Add decode
  assign slot_ok  = (32'(slot_r) < SLOTS);
  assign slot_idx = SLOT_W'(slot_r);
  assign add_err  = !slot_ok || ready_r[slot_idx];
  assign add_wr   = cmd.add_do && !add_err && (burst_r != '0);

  // Scan compare on the prio value registered at the previous issue
  assign issue  = cmd.scan_step && (idx_r < IDX_W'(SLOTS));
  assign better = pend_r && ready_r[pend_idx_r] && (!found_r || (prio_rd_r < best_prio_r));

  // Tick completion math
  assign left_new = (left_rd_r != '0) ? (left_rd_r - 1'b1) : left_rd_r;
  assign fin      = found_r && (left_new == '0);
  assign t_el     = time_r - arr_rd_r;
  assign t32      = 32'(t_el);
  assign burst32  = 32'(burst_rd_r);
  assign tat      = sat16(t32);
  assign wt       = (t32 > burst32) ? sat16(t32 - burst32) : '0;
  assign now16    = sat16(32'(time_r));

  // Memory write and registered reads
  always_ff @(posedge clk) begin
    if (add_wr) begin
      prio_mem[slot_idx]  <= prio_r;
      burst_mem[slot_idx] <= burst_r;
      left_mem[slot_idx]  <= burst_r;
      arr_mem[slot_idx]   <= time_r;
    end else if (cmd.tick_do && found_r) begin
      left_mem[best_idx_r] <= left_new;
    end
    if (issue) begin
      prio_rd_r <= prio_mem[idx_r[SLOT_W-1:0]];
    end
    if (cmd.fetch) begin
      left_rd_r  <= left_mem[best_idx_r];
      burst_rd_r <= burst_mem[best_idx_r];
      arr_rd_r   <= arr_mem[best_idx_r];
    end
  end

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      slot_r  <= in_tdata[4:0];
      prio_r  <= in_tdata[12:5];
      burst_r <= in_tdata[28:13];
    end
  end

  // Scan control and winner tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx_r   <= '0;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_r <= issue;
      if (issue) idx_r <= idx_r + 1'b1;
      if (better) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) pend_idx_r <= idx_r[SLOT_W-1:0];
    if (cmd.scan_clr) begin
      best_idx_r <= '0;
    end else if (cmd.scan_step && better) begin
      best_idx_r  <= pend_idx_r;
      best_prio_r <= prio_rd_r;
    end
  end

  // Ready mask and saturating time counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
      time_r  <= '0;
    end else begin
      if (add_wr) ready_r[slot_idx] <= 1'b1;
      if (cmd.tick_do && fin) ready_r[best_idx_r] <= 1'b0;
      if (cmd.fetch && (time_r != '1)) time_r <= time_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.add_do) begin
      out_data_r <= {now16, 16'd0, 16'd0, 1'b0, 5'd0, 1'b0, add_err};
    end else if (cmd.tick_do) begin
      out_data_r <= {now16,
                     fin ? wt : 16'd0,
                     fin ? tat : 16'd0,
                     fin,
                     found_r ? 5'(best_idx_r) : 5'd0,
                     !found_r,
                     1'b0};
    end
  end

  assign out_tdata = out_data_r;

endmodule

// ===== design/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler: controller plus datapath.
//
// Input stream (in_*): one transfer is one item. in_tuser[0] selects the kind:
// 0 adds a job (slot, prio, burst), 1 is a time tick. Every item gives exactly
// one result on the output stream (out_*).
// An add latches the item, then loads its result into the output register in the ADD state.
// A tick scans every slot through the priority memory's single read port, one
// slot per cycle, then reads the winner's record.
// One item is worked on at a time; the next input transfer is taken as soon as
// the previous result is loaded into the output register, even while that
// result still waits for out_tready.
// If the receiver stalls, the block finishes its next item and holds there
// until the waiting result has been taken.
// Reset (rst_n low, synchronous) empties all slots and clears time to zero;
// job records need no clearing since only ready slots' records are ever used.
// Time saturates at 2^TIME_BITS-1; result times saturate at 65535.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int SLOTS     = 32,
  parameter int TIME_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot[4:0], prio[12:5], burst[28:13], zero [31:29]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // add_error[0], idle[1], ran_slot[6:2], finished[7], turnaround[23:8],
  // waiting[39:24], now_time[55:40]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cmd_t    cmd;
  status_t status;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  pps_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the preemptive priority scheduler stream block.
module tb_top
  import pps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT   = 32;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PAUSE_AT     = 600;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1000000;

  // One result, last field in the lowest bits to match out_tdata
  typedef struct packed {
    logic [15:0] now_time;
    logic [15:0] waiting;
    logic [15:0] turnaround;
    logic        finished;
    logic [4:0]  ran_slot;
    logic        idle;
    logic        add_error;
  } sched_result_t;

  // Directed row; fixed result fields apply only when fixed is set
  typedef struct packed {
    logic        func;
    logic [4:0]  slot;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic        fixed;
    logic        want_err;
    logic        want_idle;
    logic [15:0] want_now;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Scheduler state as predicted from accepted transfers
  logic [7:0]            job_pri    [SLOT_COUNT];
  logic [15:0]           job_len    [SLOT_COUNT];
  logic [15:0]           job_remain [SLOT_COUNT];
  logic [15:0]           job_arrive [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occupied = '0;
  logic [15:0]           clock_now = '0;

  sched_result_t pending_results[$];
  sched_result_t observed;
  sched_result_t predicted;
  stim_row_t     script[$];
  int            mismatch_count = 0;
  int            results_seen = 0;
  int            burst_left = 0;
  int            cycle_count = 0;

  preemptive_priority_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the predicted scheduler by one item and return its result
  function automatic sched_result_t schedule_step(input logic f, input logic [4:0] s,
                                                  input logic [7:0] p, input logic [15:0] b);
    sched_result_t r;
    int            winner;
    int            i;
    logic [15:0]   span;
    r = '0;
    winner = -1;
    if (f == FUNC_ADD) begin
      if (occupied[s]) begin
        r.add_error = 1'b1;
      end else if (b != 16'd0) begin
        job_pri[s]    = p;
        job_len[s]    = b;
        job_remain[s] = b;
        job_arrive[s] = clock_now;
        occupied[s]   = 1'b1;
      end
    end else begin
      // smallest priority value wins, ties to the lowest slot
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (occupied[i] && (winner < 0 || job_pri[i] < job_pri[winner])) winner = i;
      end
      if (clock_now != 16'hFFFF) clock_now = clock_now + 16'd1;
      if (winner < 0) begin
        r.idle = 1'b1;
      end else begin
        r.ran_slot = 5'(winner);
        if (job_remain[winner] != 16'd0) job_remain[winner] = job_remain[winner] - 16'd1;
        if (job_remain[winner] == 16'd0) begin
          span = clock_now - job_arrive[winner];
          r.finished   = 1'b1;
          r.turnaround = span;
          r.waiting    = (span > job_len[winner]) ? span - job_len[winner] : 16'd0;
          occupied[winner] = 1'b0;
        end
      end
    end
    r.now_time = clock_now;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Offer one item in sender bursts; predict it once the transfer happens
  task automatic send_item(input logic f, input logic [4:0] s, input logic [7:0] p,
                           input logic [15:0] b, input logic fixed, input sched_result_t want);
    sched_result_t model;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 2) == 0) ? 60 : 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {3'b000, b, p, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model = schedule_step(f, s, p, b);
    pending_results.push_back(fixed ? want : model);
  endtask

  // Directed rows: empty tick, slot extremes, busy slot, zero burst, ties,
  // preemption by a more urgent job, and a job with the longest burst
  initial begin : fill_script
    script.push_back({FUNC_TICK, 5'd0,  8'd0,   16'd0,     1'b1, 1'b0, 1'b1, 16'd1});
    script.push_back({FUNC_ADD,  5'd0,  8'd255, 16'd1,     1'b1, 1'b0, 1'b0, 16'd1});
    script.push_back({FUNC_ADD,  5'd0,  8'd0,   16'd5,     1'b1, 1'b1, 1'b0, 16'd1});
    script.push_back({FUNC_ADD,  5'd31, 8'd0,   16'd2,     1'b1, 1'b0, 1'b0, 16'd1});
    script.push_back({FUNC_ADD,  5'd5,  8'd0,   16'd0,     1'b1, 1'b0, 1'b0, 16'd1});
    script.push_back({FUNC_TICK, 5'd31, 8'd255, 16'hFFFF,  1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_TICK, 5'd0,  8'd0,   16'd0,     1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_TICK, 5'd0,  8'd0,   16'd0,     1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_TICK, 5'd0,  8'd0,   16'd0,     1'b1, 1'b0, 1'b1, 16'd5});
    script.push_back({FUNC_ADD,  5'd10, 8'd7,   16'd3,     1'b1, 1'b0, 1'b0, 16'd5});
    script.push_back({FUNC_ADD,  5'd3,  8'd7,   16'd1,     1'b1, 1'b0, 1'b0, 16'd5});
    repeat (4) script.push_back({FUNC_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_ADD,  5'd20, 8'd100, 16'd4,     1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_TICK, 5'd0,  8'd0,   16'd0,     1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_ADD,  5'd21, 8'd50,  16'd1,     1'b0, 1'b0, 1'b0, 16'd0});
    repeat (4) script.push_back({FUNC_TICK, 5'd0, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_ADD,  5'd31, 8'd255, 16'hFFFF,  1'b0, 1'b0, 1'b0, 16'd0});
    script.push_back({FUNC_ADD,  5'd31, 8'd0,   16'h8000,  1'b1, 1'b1, 1'b0, 16'd14});
    script.push_back({FUNC_TICK, 5'd0,  8'd0,   16'd0,     1'b0, 1'b0, 1'b0, 16'd0});
  end

  // Stimulus: directed table, then random traffic
  initial begin : stimulus
    stim_row_t     row;
    sched_result_t want;
    logic [4:0]    free_list[$];
    logic [4:0]    busy_list[$];
    logic          f;
    logic [4:0]    s;
    logic [7:0]    p;
    logic [15:0]   b;
    int            n_counted;
    int            roll;
    int            i;
    bit            paused;
    n_counted = 0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      row  = script[k];
      want = '0;
      want.add_error = row.want_err;
      want.idle      = row.want_idle;
      want.now_time  = row.want_now;
      send_item(row.func, row.slot, row.prio, row.burst, row.fixed, want);
    end

    while (n_counted < RANDOM_ITEMS) begin
      // once, let everything drain before offering more
      if (n_counted == PAUSE_AT && !paused) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      free_list.delete();
      busy_list.delete();
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (occupied[i]) busy_list.push_back(5'(i));
        else free_list.push_back(5'(i));
      end
      roll = $urandom_range(0, 99);
      s = 5'($urandom_range(0, 31));
      p = 8'($urandom_range(0, 255));
      b = 16'($urandom);
      if (free_list.size() == 0 || roll < 45) begin
        f = FUNC_TICK;
      end else if (roll < 85) begin
        // well-formed job: free slot, short burst, priorities clustered for ties
        f = FUNC_ADD;
        s = free_list[$urandom_range(0, free_list.size() - 1)];
        if ($urandom_range(0, 1) == 0) p = 8'($urandom_range(0, 3));
        b = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 200)) :
                                            16'($urandom_range(1, 6));
      end else if (roll < 95) begin
        f = FUNC_ADD;
        if (busy_list.size() != 0) s = busy_list[$urandom_range(0, busy_list.size() - 1)];
      end else begin
        f = FUNC_ADD;
        b = 16'd0;
      end
      // a zero burst into a free slot changes nothing
      if (!(f == FUNC_ADD && b == 16'd0 && !occupied[s])) n_counted++;
      send_item(f, s, p, b, 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stall patterns that change every span, plus one long hold-off
  initial begin : receiver
    int  mode;
    int  span;
    int  phase;
    bit  held;
    held = 1'b0;
    phase = 0;
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_tready <= (phase % 5) < 2;
          end
        endcase
        phase++;
        @(posedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      observed = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata, 0);
      end else begin
        predicted = pending_results.pop_front();
        if (observed.add_error != predicted.add_error)
          report_mismatch("add_error", observed.add_error, predicted.add_error);
        if (observed.idle != predicted.idle)
          report_mismatch("idle", observed.idle, predicted.idle);
        if (observed.ran_slot != predicted.ran_slot)
          report_mismatch("ran_slot", observed.ran_slot, predicted.ran_slot);
        if (observed.finished != predicted.finished)
          report_mismatch("finished", observed.finished, predicted.finished);
        if (observed.turnaround != predicted.turnaround)
          report_mismatch("turnaround", observed.turnaround, predicted.turnaround);
        if (observed.waiting != predicted.waiting)
          report_mismatch("waiting", observed.waiting, predicted.waiting);
        if (observed.now_time != predicted.now_time)
          report_mismatch("now_time", observed.now_time, predicted.now_time);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
